FILE: design/tpsd_pkg.sv
// Package for the TGA pixel stream decoder: item structs, decoder state,
// configuration register indexes and phase codes. No dependencies.

package tpsd_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_LENGTH_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_BYTE_PIXELS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_PIXELS     = 2'd2;

    // Run bias subtracted from a run packet header
    localparam logic [7:0] RUN_BIAS = 8'd127;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PIXEL,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef struct packed {
        logic        run_length_mode;
        logic        four_byte_pixels;
        logic [31:0] total_pixels;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_image;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_res;
        logic       image_done;
        logic       overrun_error;
    } pixel_item_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  packet_pixels_left;
        logic        packet_is_run;
        logic [1:0]  byte_in_pixel;
        logic [31:0] colour_bytes;
        logic [31:0] pixels_done;
    } dec_state_t;

    localparam dec_state_t STATE_CLEAR = '{PH_HEADER, 8'd0, 1'b0, 2'd0, 32'd0, 32'd0};

    localparam cfg_t CFG_RESET = '{1'b1, 1'b0, 32'd1};

endpackage

FILE: design/tpsd_cfg_regs.sv
// Configuration registers of the TGA pixel stream decoder.
// Depends on tpsd_pkg for the register indexes and cfg_t.

module tpsd_cfg_regs
    import tpsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RUN_LENGTH_MODE:  cfg_next.run_length_mode  = cfg_data[0];
                CFG_FOUR_BYTE_PIXELS: cfg_next.four_byte_pixels = cfg_data[0];
                CFG_TOTAL_PIXELS:     cfg_next.total_pixels     = cfg_data;
                default:              cfg_next = cfg_reg;  // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/tpsd_step.sv
// Per-byte decode step: packet header check, pixel byte assembly and
// result build. Pure combinational. Depends on tpsd_pkg.

module tpsd_step
    import tpsd_pkg::*;
(
    input  cfg_t        cfg,
    input  dec_state_t  state_cur,
    input  byte_item_t  item,
    output dec_state_t  state_next,
    output logic        has_result,
    output pixel_item_t result
);

    dec_state_t  eff;
    logic [7:0]  b;
    logic        is_hdr;
    logic [7:0]  hdr_count;
    logic        overrun;
    logic        hdr_err;
    logic        pixel_byte;
    logic [7:0]  p_left;
    logic        p_run;
    logic [1:0]  p_bip;
    logic [31:0] p_colour;
    logic [31:0] colour_w;
    logic [1:0]  last_byte;
    logic        pix_end;
    logic [7:0]  repeat_cnt;
    logic [7:0]  left_after;
    logic [32:0] done_sum;
    logic [31:0] done_sat;
    logic        img_done;
    phase_t      phase_next;
    phase_t      pix_phase;

    // start of image clears the state before this byte is looked at
    assign eff = item.start_of_image ? STATE_CLEAR : state_cur;
    assign b   = item.data_byte;

    assign is_hdr    = (eff.phase == PH_HEADER);
    assign hdr_count = !cfg.run_length_mode ? 8'd1 :
                       b[7] ? (b - RUN_BIAS) : (b + 8'd1);
    // count > pixels left  <=>  done + count > total (count is never zero)
    assign overrun   = ({1'b0, eff.pixels_done} + {25'd0, hdr_count})
                       > {1'b0, cfg.total_pixels};
    assign hdr_err   = is_hdr && overrun;

    // plain mode: header phase opens a one-pixel raw packet and takes the byte
    assign pixel_byte = (eff.phase == PH_PIXEL) ||
                        (is_hdr && !cfg.run_length_mode && !overrun);

    assign p_left   = is_hdr ? 8'd1  : eff.packet_pixels_left;
    assign p_run    = is_hdr ? 1'b0  : eff.packet_is_run;
    assign p_bip    = is_hdr ? 2'd0  : eff.byte_in_pixel;
    assign p_colour = is_hdr ? 32'd0 : eff.colour_bytes;

    always_comb
    begin
        colour_w = p_colour;
        case (p_bip)
            2'd0:    colour_w[7:0]   = b;
            2'd1:    colour_w[15:8]  = b;
            2'd2:    colour_w[23:16] = b;
            default: colour_w[31:24] = b;
        endcase
    end

    assign last_byte  = cfg.four_byte_pixels ? 2'd3 : 2'd2;
    assign pix_end    = (p_bip >= last_byte);
    assign repeat_cnt = p_run ? p_left : 8'd1;
    assign left_after = p_run ? 8'd0 : ((p_left != 8'd0) ? (p_left - 8'd1) : 8'd0);
    assign done_sum   = {1'b0, eff.pixels_done} + {25'd0, repeat_cnt};
    assign done_sat   = done_sum[32] ? 32'hFFFF_FFFF : done_sum[31:0];
    assign img_done   = (done_sat >= cfg.total_pixels);

    // next phase
    always_comb
    begin
        if (!pix_end)
            pix_phase = PH_PIXEL;
        else if (img_done)
            pix_phase = PH_DONE;
        else if (left_after != 8'd0)
            pix_phase = PH_PIXEL;
        else
            pix_phase = PH_HEADER;

        unique case (eff.phase)
            PH_HEADER:
            begin
                if (overrun)
                    phase_next = PH_ERROR;
                else if (cfg.run_length_mode)
                    phase_next = PH_PIXEL;
                else
                    phase_next = pix_phase;
            end
            PH_PIXEL: phase_next = pix_phase;
            PH_DONE:  phase_next = PH_DONE;
            PH_ERROR: phase_next = PH_ERROR;
            default:  phase_next = PH_ERROR;
        endcase
    end

    // datapath and result
    always_comb
    begin
        state_next       = eff;
        state_next.phase = phase_next;
        has_result       = 1'b0;
        result           = '0;

        if (hdr_err)
        begin
            has_result           = 1'b1;
            result.overrun_error = 1'b1;
        end
        else if (is_hdr && cfg.run_length_mode)
        begin
            state_next.packet_pixels_left = hdr_count;
            state_next.packet_is_run      = b[7];
            state_next.byte_in_pixel      = 2'd0;
            state_next.colour_bytes       = 32'd0;
        end
        else if (pixel_byte)
        begin
            state_next.packet_is_run = p_run;
            if (!pix_end)
            begin
                state_next.packet_pixels_left = p_left;
                state_next.byte_in_pixel      = p_bip + 2'd1;
                state_next.colour_bytes       = colour_w;
            end
            else
            begin
                state_next.packet_pixels_left = left_after;
                state_next.byte_in_pixel      = 2'd0;
                state_next.colour_bytes       = 32'd0;
                state_next.pixels_done        = done_sat;
                has_result                    = 1'b1;
                result.red                    = colour_w[23:16];
                result.green                  = colour_w[15:8];
                result.blue                   = colour_w[7:0];
                result.alpha                  = cfg.four_byte_pixels ? colour_w[31:24] : 8'd0;
                result.repeat_res             = repeat_cnt;
                result.image_done             = img_done;
            end
        end
    end

endmodule

FILE: design/tga_pixel_stream_decoder.sv
// Top level of the TGA pixel stream decoder: input register, decoder state,
// result register. Uses tpsd_pkg, tpsd_cfg_regs and tpsd_step.
//
//  channel  direction  handshake                 payload
//  byte     in         byte_valid / byte_ready   byte_item  (byte_item_t)
//  pixel    out        pixel_valid / pixel_ready pixel_item (pixel_item_t)
//  cfg      in         cfg_write                 cfg_index, cfg_data
//
// One item per cycle sustained unless a stalled result holds it back; an item
// goes through the input register, then decode into the result register.
// The decode step uses 33-bit adds on the pixel counter (overrun check and count).
// Reset puts the decoder at the first packet header with counters cleared.
// A stalled result holds its item in the input register; items that give
// no result still advance while the result register waits.

module tga_pixel_stream_decoder
    import tpsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  byte_item_t             byte_item,
    output logic                   pixel_valid,
    input  logic                   pixel_ready,
    output pixel_item_t            pixel_item,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t        cfg;
    logic        s1_valid_reg;
    byte_item_t  s1_item_reg;
    dec_state_t  state_reg;
    dec_state_t  state_next;
    logic        pixel_valid_reg;
    pixel_item_t pixel_item_reg;
    logic        step_has_result;
    pixel_item_t step_result;
    logic        step_fire;

    tpsd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpsd_step u_step (
        .cfg        (cfg),
        .state_cur  (state_reg),
        .item       (s1_item_reg),
        .state_next (state_next),
        .has_result (step_has_result),
        .result     (step_result)
    );

    assign step_fire  = s1_valid_reg &&
                        (!pixel_valid_reg || pixel_ready || !step_has_result);
    assign byte_ready = !s1_valid_reg || step_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            state_reg       <= STATE_CLEAR;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_ready)
                s1_valid_reg <= byte_valid;
            if (step_fire)
                state_reg <= state_next;
            if (step_fire && step_has_result)
                pixel_valid_reg <= 1'b1;
            else if (pixel_ready)
                pixel_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
            s1_item_reg <= byte_item;
        if (step_fire && step_has_result)
            pixel_item_reg <= step_result;
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel_item  = pixel_item_reg;

endmodule

FILE: design/tpsd_checker.sv
// Port-level checks for the TGA pixel stream decoder, bound to the top level.
// Depends on tpsd_pkg.

module tpsd_checker
    import tpsd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   byte_ready,
    input logic                   pixel_valid,
    input logic                   pixel_ready,
    input pixel_item_t            pixel_item
);

    // an error item carries nothing but the error flag
    a_error_item_clean: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_item.overrun_error |->
            pixel_item.repeat_res == 8'd0 && !pixel_item.image_done &&
            pixel_item.red == 8'd0 && pixel_item.green == 8'd0 &&
            pixel_item.blue == 8'd0 && pixel_item.alpha == 8'd0)
        else $error("error item with nonzero payload");

    // a pixel item always repeats at least once and at most one run
    a_repeat_range: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_item.overrun_error |->
            pixel_item.repeat_res != 8'd0 && pixel_item.repeat_res <= 8'd128)
        else $error("pixel item repeat count out of range");

    // with the result register empty nothing can hold the input side back
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_valid |-> byte_ready)
        else $error("byte channel stalled with no pending item");

    a_pixel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel_item))
        else $error("stalled pixel item changed");

endmodule

bind tga_pixel_stream_decoder tpsd_checker u_tpsd_checker (.*);

FILE: bench/tb_top.sv
// Testbench for tga_pixel_stream_decoder: directed table then random TGA pixel streams,
// every result checked against an in-bench decoder model or an expected table entry.
// Depends on tpsd_pkg and the decoder RTL only.

module tb_top;
    import tpsd_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_ITEMS = 1050;
    localparam logic [31:0] TOTAL_MAX    = 32'd4294836225;

    localparam pixel_item_t NO_PIXEL     = '0;
    localparam pixel_item_t OVERRUN_ITEM = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1};

    typedef enum logic { ROW_BYTE, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [31:0]            value;
        logic                   sof;
        bit                     typed;
        pixel_item_t            want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   byte_valid;
    logic                   byte_ready;
    byte_item_t             byte_item;
    logic                   pixel_valid;
    logic                   pixel_ready;
    pixel_item_t            pixel_item;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tga_pixel_stream_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_item   (byte_item),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_item  (pixel_item),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Decoder model: settings and image state
    logic        cfg_rle;
    logic        cfg_four;
    logic [31:0] cfg_total;
    phase_t      dec_phase;
    logic [7:0]  run_left;
    logic        run_flag;
    logic [1:0]  byte_pos;
    logic [31:0] pix_bytes;
    logic [31:0] pix_count;

    pixel_item_t pending_pixels[$];
    stim_row_t   directed_rows[$];
    int          error_count   = 0;
    int          sent_items    = 0;
    int          burst_left    = 1;
    bit          sof_pending   = 0;
    int          stall_clock   = 0;
    int          stall_mode    = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void start_image();
        dec_phase = PH_HEADER;
        run_left  = 8'd0;
        run_flag  = 1'b0;
        byte_pos  = 2'd0;
        pix_bytes = 32'd0;
        pix_count = 32'd0;
    endfunction

    // Returns 1 when the byte completes a pixel or trips the overrun check.
    function automatic bit decode_byte(input logic [7:0] b, input logic sof,
                                       output pixel_item_t res);
        logic [31:0] left;
        logic [31:0] need;
        logic [7:0]  rep;
        logic [32:0] sum;
        res     = '0;
        if (sof)
            start_image();
        if (dec_phase == PH_DONE || dec_phase == PH_ERROR)
            return 1'b0;
        if (dec_phase == PH_HEADER)
        begin
            left = (pix_count < cfg_total) ? cfg_total - pix_count : 32'd0;
            if (!cfg_rle)
                need = 32'd1;
            else if (b < 8'd128)
                need = {24'd0, b} + 32'd1;
            else
                need = {24'd0, b} - 32'd127;
            if (need > left)
            begin
                res       = OVERRUN_ITEM;
                dec_phase = PH_ERROR;
                return 1'b1;
            end
            run_left  = need[7:0];
            run_flag  = cfg_rle & b[7];
            byte_pos  = 2'd0;
            pix_bytes = 32'd0;
            dec_phase = PH_PIXEL;
            if (cfg_rle)
                return 1'b0;
        end
        pix_bytes[8*byte_pos +: 8] = b;
        if (byte_pos < (cfg_four ? 2'd3 : 2'd2))
        begin
            byte_pos = byte_pos + 2'd1;
            return 1'b0;
        end
        byte_pos = 2'd0;
        if (run_flag)
        begin
            rep      = run_left;
            run_left = 8'd0;
        end
        else
        begin
            rep = 8'd1;
            if (run_left != 8'd0)
                run_left = run_left - 8'd1;
        end
        sum       = {1'b0, pix_count} + {25'd0, rep};
        pix_count = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        res.red        = pix_bytes[23:16];
        res.green      = pix_bytes[15:8];
        res.blue       = pix_bytes[7:0];
        res.alpha      = cfg_four ? pix_bytes[31:24] : 8'd0;
        res.repeat_res = rep;
        if (pix_count >= cfg_total)
        begin
            dec_phase       = PH_DONE;
            res.image_done  = 1'b1;
        end
        else
        begin
            dec_phase = (run_left != 8'd0) ? PH_PIXEL : PH_HEADER;
        end
        pix_bytes = 32'd0;
        return 1'b1;
    endfunction

    function automatic stim_row_t byte_row(input logic [7:0] data, input logic sof,
                                           input bit typed = 1'b0,
                                           input pixel_item_t want = NO_PIXEL);
        return '{ROW_BYTE, CFG_RUN_LENGTH_MODE, {24'd0, data}, sof, typed, want};
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [31:0] val);
        return '{ROW_REG, idx, val, 1'b0, 1'b0, NO_PIXEL};
    endfunction

    // Called at a falling edge; returns at a falling edge with nothing assigned yet.
    task automatic send_byte(input logic [7:0] data, input logic sof, input bit typed,
                             input pixel_item_t want);
        pixel_item_t res;
        bit          got;
        int          gap;
        byte_valid <= 1'b1;
        byte_item  <= '{data_byte: data, start_of_image: sof};
        do
            @(posedge clk);
        while (!byte_ready);
        got = decode_byte(data, sof, res);
        if (typed)
            pending_pixels.push_back(want);
        else if (got)
            pending_pixels.push_back(res);
        sent_items++;
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] data);
        send_byte(data, sof_pending, 1'b0, NO_PIXEL);
        sof_pending = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        byte_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        // bytes that give no result may still sit in the pipeline
        repeat (6) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_RUN_LENGTH_MODE:  cfg_rle   = val[0];
            CFG_FOUR_BYTE_PIXELS: cfg_four  = val[0];
            CFG_TOTAL_PIXELS:     cfg_total = val;
            default: ;
        endcase
    endtask

    task automatic send_pixels(input int count);
        repeat (count * (cfg_four ? 4 : 3)) push_byte(8'($urandom_range(0, 255)));
    endtask

    // One image of well-formed packets, with an occasional packet that overruns.
    task automatic gen_image(input int budget);
        logic [31:0] remaining;
        int          count;
        int          cap;
        int          packets;
        bit          run;
        bit          over;
        remaining = cfg_total;
        packets   = 0;
        while (remaining != 0 && sent_items < budget && packets < 400)
        begin
            if (!cfg_rle)
            begin
                send_pixels(1);
                remaining = remaining - 1;
            end
            else
            begin
                cap  = (remaining < 128) ? remaining : 128;
                over = (remaining < 128) && ($urandom_range(0, 15) == 0);
                run  = 1'($urandom_range(0, 1));
                if (over)
                    count = $urandom_range(remaining + 1, 128);
                else if (run)
                    count = $urandom_range(1, cap);
                else
                    count = $urandom_range(1, (cap < 6) ? cap : 6);
                push_byte(8'(run ? count + 127 : count - 1));
                if (over)
                begin
                    send_pixels(1);
                    remaining = 0;
                end
                else
                begin
                    send_pixels(run ? 1 : count);
                    remaining = remaining - count;
                end
            end
            packets++;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        pixel_item_t want;
        if (rst_n && pixel_valid && pixel_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected pixel item: %h", pixel_item);
                error_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("red", want.red, pixel_item.red);
                check_field("green", want.green, pixel_item.green);
                check_field("blue", want.blue, pixel_item.blue);
                check_field("alpha", want.alpha, pixel_item.alpha);
                check_field("repeat_res", want.repeat_res, pixel_item.repeat_res);
                check_field("image_done", {7'd0, want.image_done},
                            {7'd0, pixel_item.image_done});
                check_field("overrun_error", {7'd0, want.overrun_error},
                            {7'd0, pixel_item.overrun_error});
            end
        end
    end

    // Receiver back-pressure: a stall pattern picked at random from four modes.
    always @(negedge clk)
    begin
        stall_clock++;
        if (stall_clock % 300 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       pixel_ready <= 1'b1;
            1:       pixel_ready <= 1'($urandom_range(0, 1));
            2:       pixel_ready <= (stall_clock % 8 == 0);
            default: pixel_ready <= ((stall_clock / 16) % 2 == 0);
        endcase
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [31:0] total;
        int          random_target;
        int          budget;
        clk         = 1'b0;
        rst_n       = 1'b0;
        byte_valid  = 1'b0;
        byte_item   = '0;
        pixel_ready = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cfg_rle     = CFG_RESET.run_length_mode;
        cfg_four    = CFG_RESET.four_byte_pixels;
        cfg_total   = CFG_RESET.total_pixels;
        start_image();

        // reset settings: one pixel, then done; a second image overruns
        directed_rows.push_back(byte_row(8'h80, 1'b1));
        directed_rows.push_back(byte_row(8'h11, 1'b0));
        directed_rows.push_back(byte_row(8'h22, 1'b0));
        directed_rows.push_back(byte_row(8'h33, 1'b0, 1'b1,
                                '{8'h33, 8'h22, 8'h11, 8'h00, 8'd1, 1'b1, 1'b0}));
        directed_rows.push_back(byte_row(8'h05, 1'b0));
        directed_rows.push_back(byte_row(8'h01, 1'b1, 1'b1, OVERRUN_ITEM));
        // longest run and longest raw packet, BGRA
        directed_rows.push_back(reg_row(CFG_TOTAL_PIXELS, TOTAL_MAX));
        directed_rows.push_back(reg_row(CFG_FOUR_BYTE_PIXELS, 32'd1));
        directed_rows.push_back(byte_row(8'hFF, 1'b1));
        directed_rows.push_back(byte_row(8'h00, 1'b0));
        directed_rows.push_back(byte_row(8'hFF, 1'b0));
        directed_rows.push_back(byte_row(8'hA5, 1'b0));
        directed_rows.push_back(byte_row(8'h5A, 1'b0, 1'b1,
                                '{8'hA5, 8'hFF, 8'h00, 8'h5A, 8'd128, 1'b0, 1'b0}));
        directed_rows.push_back(byte_row(8'h7F, 1'b0));
        repeat (4) directed_rows.push_back(byte_row(8'hFF, 1'b0));
        // plain mode, then an image shortened under a pixel already counted
        directed_rows.push_back(reg_row(CFG_RUN_LENGTH_MODE, 32'd0));
        directed_rows.push_back(reg_row(CFG_FOUR_BYTE_PIXELS, 32'd0));
        directed_rows.push_back(reg_row(CFG_TOTAL_PIXELS, 32'd2));
        directed_rows.push_back(byte_row(8'h01, 1'b1));
        directed_rows.push_back(byte_row(8'h02, 1'b0));
        directed_rows.push_back(byte_row(8'h03, 1'b0));
        directed_rows.push_back(reg_row(CFG_TOTAL_PIXELS, 32'd1));
        directed_rows.push_back(byte_row(8'h44, 1'b0, 1'b1, OVERRUN_ITEM));
        directed_rows.push_back(byte_row(8'h01, 1'b1));
        directed_rows.push_back(byte_row(8'h80, 1'b0));
        directed_rows.push_back(byte_row(8'hFE, 1'b0, 1'b1,
                                '{8'hFE, 8'h80, 8'h01, 8'h00, 8'd1, 1'b1, 1'b0}));
        directed_rows.push_back(byte_row(8'h9C, 1'b0));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            else
                send_byte(directed_rows[i].value[7:0], directed_rows[i].sof,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        random_target = sent_items + RANDOM_ITEMS;
        while (sent_items < random_target)
        begin
            write_reg(CFG_RUN_LENGTH_MODE, {31'd0, $urandom_range(0, 3) != 0});
            write_reg(CFG_FOUR_BYTE_PIXELS, {31'd0, $urandom_range(0, 1) == 1});
            case ($urandom_range(0, 9))
                0: total = 32'd1;
                1: total = TOTAL_MAX;
                2:
                begin
                    total = $urandom;
                    if (total == 32'd0 || total > TOTAL_MAX)
                        total = TOTAL_MAX;
                end
                3: total = $urandom_range(100, 600);
                default: total = $urandom_range(1, 24);
            endcase
            write_reg(CFG_TOTAL_PIXELS, total);
            // without a fresh start the new settings land mid-image
            sof_pending = ($urandom_range(0, 2) != 0);
            budget = sent_items + $urandom_range(30, 120);
            while (sent_items < budget)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    repeat ($urandom_range(3, 20))
                        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                                  1'b0, NO_PIXEL);
                end
                else
                begin
                    gen_image(budget);
                    if ($urandom_range(0, 3) == 0)
                        push_byte(8'($urandom_range(0, 255)));
                end
                sof_pending = 1'b1;
            end
        end

        byte_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
